>>> sv/gbnms_pkg.sv
package gbnms_pkg;
  localparam int MaxBoxes = 64;
  localparam int IdxW = $clog2(MaxBoxes);
  localparam int CntW = IdxW + 1;

  localparam logic [1:0] CfgScoreThr = 2'd0;
  localparam logic [1:0] CfgOverlapThr = 2'd1;
  localparam logic [1:0] CfgDecay = 2'd2;
  localparam logic [1:0] CfgKeepLimit = 2'd3;

  typedef struct packed {
    logic signed [15:0] ymax;
    logic signed [15:0] xmax;
    logic signed [15:0] ymin;
    logic signed [15:0] xmin;
  } corners_t;
endpackage

>>> sv/greedy_box_nms_unit.sv
// Greedy box non-maximum suppression. Boxes load one word per cycle until the
// last_box word; the block then deasserts box_ready_o while it insertion-sorts the
// candidates (a read and a compare step per box and per shift step) and runs greedy
// suppression, where each candidate is tested against each kept box in the
// shared three-stage overlap unit. Results then leave one at a time, each held
// until accepted, and loading resumes after the last one is taken.
module greedy_box_nms_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               box_valid_i,
  output logic               box_ready_o,
  input  logic signed [15:0] box_xmin_i,
  input  logic signed [15:0] box_ymin_i,
  input  logic signed [15:0] box_xmax_i,
  input  logic signed [15:0] box_ymax_i,
  input  logic [31:0]        box_area_i,
  input  logic [15:0]        box_score_i,
  input  logic               last_box_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [5:0]         kept_index_o,
  output logic [15:0]        kept_score_o,
  output logic               none_kept_o,
  output logic               last_result_o
);
  import gbnms_pkg::*;

  logic [15:0]       score_thr_q;
  logic [16:0]       overlap_thr_q, decay_q;
  logic signed [7:0] keep_limit_q;
  corners_t          corners;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q   <= '0;
      overlap_thr_q <= 17'd29491;
      decay_q       <= 17'd65536;
      keep_limit_q  <= -8'sd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgScoreThr:   score_thr_q   <= cfg_data_i[15:0];
        CfgOverlapThr: overlap_thr_q <= cfg_data_i;
        CfgDecay:      decay_q       <= cfg_data_i;
        CfgKeepLimit:  keep_limit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign corners = '{ymax: box_ymax_i, xmax: box_xmax_i, ymin: box_ymin_i, xmin: box_xmin_i};

  gbnms_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .score_thr_i   (score_thr_q),
    .overlap_thr_i (overlap_thr_q),
    .decay_i       (decay_q),
    .keep_limit_i  (keep_limit_q),
    .in_fire_i     (box_valid_i && box_ready_o),
    .in_corners_i  (corners),
    .in_area_i     (box_area_i),
    .in_score_i    (box_score_i),
    .in_last_i     (last_box_i),
    .in_ready_o    (box_ready_o),
    .out_valid_o   (res_valid_o),
    .out_ready_i   (res_ready_i),
    .out_index_o   (kept_index_o),
    .out_score_o   (kept_score_o),
    .out_none_o    (none_kept_o),
    .out_last_o    (last_result_o)
  );

  a_no_overlap_of_phases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(box_ready_o && res_valid_o)) else $error("load and result phases overlap");
  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && none_kept_o |-> last_result_o) else $error("empty result not last");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && none_kept_o |-> kept_score_o == '0 && kept_index_o == '0)
    else $error("empty result carries data");
endmodule

>>> sv/gbnms_overlap.sv
// Overlap unit: a three-stage pipeline that decides whether the intersection over
// union of two boxes exceeds the current limit. Each stage holds at most one multiply.
module gbnms_overlap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  gbnms_pkg::corners_t a_i,
  input  gbnms_pkg::corners_t b_i,
  input  logic [31:0]         area_a_i,
  input  logic [31:0]         area_b_i,
  input  logic [16:0]         limit_i,
  output logic                done_o,
  output logic                hit_o
);
  import gbnms_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic               ok1_q, ok2_q;
  logic signed [17:0] w_q, h_q;
  logic [32:0]        asum1_q, asum2_q;
  logic [16:0]        lim1_q, lim2_q;
  logic [35:0]        inter_q;
  logic               hit_q;

  logic signed [15:0] x0, y0, x1, y1;
  logic signed [17:0] w_d, h_d;
  logic               ok1_d;
  logic signed [35:0] wh;
  logic signed [37:0] uni;
  logic [53:0]        lhs, rhs;

  always_comb begin
    x0 = (a_i.xmin > b_i.xmin) ? a_i.xmin : b_i.xmin;
    y0 = (a_i.ymin > b_i.ymin) ? a_i.ymin : b_i.ymin;
    x1 = (a_i.xmax < b_i.xmax) ? a_i.xmax : b_i.xmax;
    y1 = (a_i.ymax < b_i.ymax) ? a_i.ymax : b_i.ymax;
    w_d = 18'(x1) - 18'(x0);
    h_d = 18'(y1) - 18'(y0);
    ok1_d = (w_d > 0) && (h_d > 0);
    wh = 36'(w_q) * 36'(h_q);
    uni = 38'($signed({5'd0, asum2_q})) - 38'($signed({2'd0, inter_q}));
    lhs = {2'd0, inter_q, 16'd0};
    rhs = 54'(lim2_q) * 54'(uni[36:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_q   <= ok1_d;
    w_q     <= w_d;
    h_q     <= h_d;
    asum1_q <= 33'(area_a_i) + 33'(area_b_i);
    lim1_q  <= limit_i;
    ok2_q   <= ok1_q;
    inter_q <= wh[35:0];
    asum2_q <= asum1_q;
    lim2_q  <= lim1_q;
    // A union that is not positive counts as no overlap.
    hit_q   <= ok2_q && (uni > 0) && (lhs > rhs);
  end

  assign done_o = v3_q;
  assign hit_o  = hit_q;
endmodule

>>> sv/gbnms_seq.sv
// Sequencer with the box stores: loads words, sorts by insertion, then runs
// greedy suppression over the shared overlap unit and streams the kept list.
module gbnms_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         score_thr_i,
  input  logic [16:0]         overlap_thr_i,
  input  logic [16:0]         decay_i,
  input  logic signed [7:0]   keep_limit_i,
  input  logic                in_fire_i,
  input  gbnms_pkg::corners_t in_corners_i,
  input  logic [31:0]         in_area_i,
  input  logic [15:0]         in_score_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [5:0]          out_index_o,
  output logic [15:0]         out_score_o,
  output logic                out_none_o,
  output logic                out_last_o
);
  import gbnms_pkg::*;

  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StSelRd  = 4'd1;
  localparam logic [3:0] StSelCmp = 4'd2;
  localparam logic [3:0] StShRd   = 4'd3;
  localparam logic [3:0] StShCmp  = 4'd4;
  localparam logic [3:0] StCandRd = 4'd5;
  localparam logic [3:0] StKeptRd = 4'd6;
  localparam logic [3:0] StOvl    = 4'd7;
  localparam logic [3:0] StOvlW   = 4'd8;
  localparam logic [3:0] StDecay  = 4'd9;
  localparam logic [3:0] StOutRd  = 4'd10;
  localparam logic [3:0] StOut    = 4'd11;
  localparam logic [3:0] StCandA  = 4'd12;
  localparam logic [3:0] StOutSc  = 4'd13;

  corners_t    corner_mem [MaxBoxes];
  logic [31:0] area_mem [MaxBoxes];
  logic [15:0] score_mem [MaxBoxes];
  logic [15:0] sscore_mem [MaxBoxes];
  logic [IdxW-1:0] order_mem [MaxBoxes];
  logic [IdxW-1:0] kept_mem [MaxBoxes];

  logic [3:0]      st_q, st_d;
  logic [CntW-1:0] load_q, i_q, j_q, ncand_q, nkept_q, c_q, k_q;
  logic [16:0]     lim_q;
  logic [15:0]     cur_score_q;
  logic [IdxW-1:0] cand_q;
  corners_t        ca_q, rd_corner_q;
  logic [31:0]     aa_q, rd_area_q;
  logic [15:0]     rd_score_q, rd_sscore_q;
  logic [IdxW-1:0] rd_order_q, rd_kept_q;
  logic            ovl_start;
  logic            ovl_done, ovl_hit;
  logic [33:0]     prod;
  logic [CntW-1:0] lim_cnt;

  // Read ports: corner/area/score addressed by one index, order/sorted score by a second, kept by a third.
  logic [IdxW-1:0] rd_box, rd_ord, rd_kept;
  logic            wr_ord;
  logic [IdxW-1:0] wr_ord_a, wr_ord_v;
  logic [15:0]     wr_ord_s;

  always_comb begin
    rd_box  = i_q[IdxW-1:0];
    rd_ord  = j_q[IdxW-1:0] - 1'b1;
    rd_kept = k_q[IdxW-1:0];
    if (st_q == StCandRd || st_q == StOutRd || st_q == StCandA) rd_ord = c_q[IdxW-1:0];
    if (st_q == StKeptRd || st_q == StOvl) rd_box = rd_kept_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && load_q < CntW'(MaxBoxes)) begin
      corner_mem[load_q[IdxW-1:0]] <= in_corners_i;
      area_mem[load_q[IdxW-1:0]]   <= in_area_i;
      score_mem[load_q[IdxW-1:0]]  <= in_score_i;
    end
    if (wr_ord) begin
      order_mem[wr_ord_a]  <= wr_ord_v;
      sscore_mem[wr_ord_a] <= wr_ord_s;
    end
    if (st_q == StDecay) kept_mem[nkept_q[IdxW-1:0]] <= cand_q;
    rd_corner_q <= corner_mem[rd_box];
    rd_area_q   <= area_mem[rd_box];
    rd_score_q  <= score_mem[rd_box];
    rd_order_q  <= order_mem[rd_ord];
    rd_sscore_q <= sscore_mem[rd_ord];
    rd_kept_q   <= kept_mem[rd_kept];
  end

  assign prod = 34'(lim_q) * 34'(decay_i);

  always_comb begin
    lim_cnt = ncand_q;
    if (!keep_limit_i[7] && CntW'(keep_limit_i[6:0]) < ncand_q) lim_cnt = CntW'(keep_limit_i[6:0]);
  end

  always_comb begin
    st_d      = st_q;
    wr_ord    = 1'b0;
    wr_ord_a  = j_q[IdxW-1:0];
    wr_ord_v  = i_q[IdxW-1:0];
    wr_ord_s  = cur_score_q;
    ovl_start = 1'b0;
    case (st_q)
      StLoad:   if (in_fire_i && in_last_i) st_d = StSelRd;
      StSelRd: begin
        if (i_q >= load_q) st_d = (lim_cnt == '0) ? StOut : StCandRd;
        else st_d = StSelCmp;
      end
      StSelCmp: st_d = (rd_score_q > score_thr_i) ? StShRd : StSelRd;
      StShRd:   st_d = StShCmp;
      StShCmp: begin
        if (j_q != '0 && rd_sscore_q < cur_score_q) begin
          wr_ord   = 1'b1;
          wr_ord_v = rd_order_q;
          wr_ord_s = rd_sscore_q;
          st_d     = StShRd;
        end else begin
          wr_ord = 1'b1;
          st_d   = StSelRd;
        end
      end
      StCandRd: begin
        if (c_q >= ncand_q) st_d = (nkept_q == '0) ? StOut : StOutRd;
        else st_d = StCandA;
      end
      StCandA:  st_d = StKeptRd;
      StKeptRd: st_d = (k_q >= nkept_q) ? StDecay : StOvl;
      StOvl: begin
        ovl_start = 1'b1;
        st_d = StOvlW;
      end
      StOvlW:   if (ovl_done) st_d = ovl_hit ? StCandRd : StKeptRd;
      StDecay:  st_d = StCandRd;
      StOutRd:  st_d = StOutSc;
      StOutSc:  st_d = StOut;
      StOut:    if (out_ready_i) st_d = out_last_o ? StLoad : StOutRd;
      default:  st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StLoad;
      load_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ncand_q <= '0;
      nkept_q <= '0;
      c_q     <= '0;
      k_q     <= '0;
      lim_q   <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        StLoad: begin
          if (in_fire_i && load_q < CntW'(MaxBoxes)) load_q <= load_q + 1'b1;
          i_q <= '0;
          ncand_q <= '0;
        end
        StSelRd: begin
          if (i_q >= load_q) begin
            // Selection done: start suppression at the first sorted candidate.
            ncand_q <= lim_cnt;
            c_q     <= '0;
            nkept_q <= '0;
            lim_q   <= overlap_thr_i;
          end
        end
        StSelCmp: begin
          if (rd_score_q > score_thr_i) begin
            j_q <= ncand_q;
            ncand_q <= ncand_q + 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        StShCmp: begin
          if (j_q != '0 && rd_sscore_q < cur_score_q) j_q <= j_q - 1'b1;
          else i_q <= i_q + 1'b1;
        end
        StCandRd: begin
          // The kept list is walked from its start, so its first entry is read next.
          k_q <= '0;
          if (c_q >= ncand_q) c_q <= '0;
        end
        StKeptRd: if (k_q < nkept_q) k_q <= k_q + 1'b1;
        StOvlW: if (ovl_done && ovl_hit) c_q <= c_q + 1'b1;
        StDecay: begin
          nkept_q <= nkept_q + 1'b1;
          c_q     <= c_q + 1'b1;
          if (decay_i < 17'd65536 && lim_q > 17'd32768) lim_q <= prod[32:16];
        end
        StOutRd: ;
        StOut: begin
          if (out_ready_i) begin
            k_q <= k_q + 1'b1;
            if (out_last_o) load_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload held beside the control path.
  logic [IdxW-1:0] out_idx_q;
  logic [15:0]     out_sc_q;
  always_ff @(posedge clk_i) begin
    if (st_q == StSelCmp) cur_score_q <= rd_score_q;
    if (st_q == StCandA) begin
      cand_q <= rd_order_q;
    end
    if (st_q == StKeptRd) begin
      ca_q <= corner_mem[cand_q];
      aa_q <= area_mem[cand_q];
    end
    // The kept entry at k arrives from the read stage; its score is read from it.
    if (st_q == StOutSc) begin
      out_idx_q <= rd_kept_q;
      out_sc_q  <= score_mem[rd_kept_q];
    end
  end

  gbnms_overlap u_ovl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ovl_start),
    .a_i      (ca_q),
    .b_i      (rd_corner_q),
    .area_a_i (aa_q),
    .area_b_i (rd_area_q),
    .limit_i  (lim_q),
    .done_o   (ovl_done),
    .hit_o    (ovl_hit)
  );

  logic none;
  assign none        = (nkept_q == '0);
  assign in_ready_o  = (st_q == StLoad);
  assign out_valid_o = (st_q == StOut);
  assign out_none_o  = none;
  assign out_last_o  = none || (k_q + 1'b1 == nkept_q);
  assign out_index_o = none ? '0 : 6'(out_idx_q);
  assign out_score_o = none ? '0 : out_sc_q;
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gbnms_pkg::*;

  typedef struct {
    logic signed [15:0] x0, y0, x1, y1;
    logic [31:0]        area;
    logic [15:0]        score;
    logic               last;
  } box_word_t;

  typedef struct {
    logic [5:0]  index;
    logic [15:0] score;
    logic        none;
    logic        last;
  } kept_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = CfgScoreThr;
  logic [16:0]        cfg_data_i = '0;
  logic               box_valid_i = 1'b0;
  logic               box_ready_o;
  logic signed [15:0] box_xmin_i = '0, box_ymin_i = '0, box_xmax_i = '0, box_ymax_i = '0;
  logic [31:0]        box_area_i = '0;
  logic [15:0]        box_score_i = '0;
  logic               last_box_i = 1'b0;
  logic               res_valid_o;
  logic               res_ready_i = 1'b0;
  logic [5:0]         kept_index_o;
  logic [15:0]        kept_score_o;
  logic               none_kept_o;
  logic               last_result_o;

  greedy_box_nms_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and register copies.
  logic [15:0]       thr_score = 16'd0;
  logic [16:0]       thr_overlap = 17'd29491;
  logic [16:0]       decay = 17'd65536;
  logic [7:0]        keep_max = 8'hFF;
  box_word_t         stored[MaxBoxes];
  int unsigned       stored_count = 0;

  box_word_t         pending_boxes[$];
  kept_word_t        kept_due[$];

  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                long_hold_req = 1'b0;
  bit                box_taken = 1'b0;
  int                errors = 0;
  int                n_sets = 0, n_boxes = 0, n_results = 0, n_none = 0;
  int                quiet_cycles = 0;

  function automatic bit boxes_clash(int a, int b, logic [16:0] lim);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, w, h, inter, uni;
    ax0 = stored[a].x0; ay0 = stored[a].y0; ax1 = stored[a].x1; ay1 = stored[a].y1;
    bx0 = stored[b].x0; by0 = stored[b].y0; bx1 = stored[b].x1; by1 = stored[b].y1;
    if (bx0 > ax1 || bx1 < ax0 || by0 > ay1 || by1 < ay0) return 1'b0;
    w = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
    h = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
    if (w <= 0 || h <= 0) return 1'b0;
    inter = w * h;
    uni = longint'(stored[a].area) + longint'(stored[b].area) - inter;
    if (uni <= 0) return 1'b0;
    return inter * 65536 > longint'(lim) * uni;
  endfunction

  // Stores one word and, on the final word of a set, predicts the kept list.
  task automatic absorb_box(box_word_t b);
    int order[$];
    int kept[$];
    int j;
    bit keep;
    logic [16:0] lim;
    kept_word_t r;
    if (stored_count < MaxBoxes) begin
      stored[stored_count] = b;
      stored_count++;
    end
    n_boxes++;
    if (!b.last) return;
    n_sets++;
    for (int i = 0; i < stored_count; i++) begin
      if (stored[i].score > thr_score) begin
        j = order.size();
        order = {order, i};
        while (j > 0 && stored[order[j-1]].score < stored[i].score) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
    end
    if (!keep_max[7] && keep_max < order.size())
      while (order.size() > keep_max) void'(order.pop_back());
    lim = thr_overlap;
    foreach (order[i]) begin
      keep = 1'b1;
      foreach (kept[k]) if (keep && boxes_clash(order[i], kept[k], lim)) keep = 1'b0;
      if (keep) begin
        kept = {kept, order[i]};
        if (decay < 17'd65536 && lim > 17'd32768)
          lim = 17'((34'(lim) * 34'(decay)) >> 16);
      end
    end
    stored_count = 0;
    if (kept.size() == 0) begin
      r = '{index: '0, score: '0, none: 1'b1, last: 1'b1};
      kept_due = {kept_due, r};
    end else begin
      foreach (kept[k]) begin
        r = '{index: 6'(kept[k]), score: stored[kept[k]].score, none: 1'b0,
              last: (k == kept.size() - 1)};
        kept_due = {kept_due, r};
      end
    end
  endtask

  // Sampling side: acceptances, checks and the watchdog.
  always @(posedge clk_i) begin
    kept_word_t want;
    box_taken = box_valid_i && box_ready_o;
    if (box_taken) absorb_box('{box_xmin_i, box_ymin_i, box_xmax_i, box_ymax_i,
                                box_area_i, box_score_i, last_box_i});
    if (res_valid_o && res_ready_i) begin
      n_results++;
      if (none_kept_o) n_none++;
      if (kept_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: index %0d score %0d", kept_index_o,
                                   kept_score_o);
      end else begin
        want = kept_due.pop_front();
        if (want.index !== kept_index_o || want.score !== kept_score_o ||
            want.none !== none_kept_o || want.last !== last_result_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected idx %0d score %0d none %b last %b, got %0d %0d %b %b",
                     want.index, want.score, want.none, want.last,
                     kept_index_o, kept_score_o, none_kept_o, last_result_o);
        end
      end
    end
    if (box_taken || (res_valid_o && res_ready_i) || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 100000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Box driver.
  always @(negedge clk_i) begin
    box_word_t b;
    if (rst_ni && (!box_valid_i || box_taken)) begin
      if (pending_boxes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        b = pending_boxes.pop_front();
        box_xmin_i <= b.x0; box_ymin_i <= b.y0; box_xmax_i <= b.x1; box_ymax_i <= b.y1;
        box_area_i <= b.area; box_score_i <= b.score; last_box_i <= b.last;
        box_valid_i <= 1'b1;
      end else begin
        box_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver, with a long hold-off, when requested, once results are waiting.
  int hold_left = 0;
  always @(negedge clk_i) begin
    if (long_hold_req && res_valid_o) begin
      long_hold_req = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready_i <= 1'b0;
    end else begin
      res_ready_i <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic box_word_t rand_box(bit last);
    box_word_t b;
    int cx, cy, hw, hh;
    if ($urandom_range(0, 9) == 0) begin
      b.x0 = 16'($urandom); b.y0 = 16'($urandom);
      b.x1 = 16'($urandom); b.y1 = 16'($urandom);
      b.area = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
    end else begin
      cx = $urandom_range(0, 6000) - 3000; cy = $urandom_range(0, 6000) - 3000;
      hw = $urandom_range(1, 3000); hh = $urandom_range(1, 3000);
      b.x0 = 16'(cx - hw); b.x1 = 16'(cx + hw); b.y0 = 16'(cy - hh); b.y1 = 16'(cy + hh);
      b.area = 32'(4 * hw * hh);
      if ($urandom_range(0, 15) == 0) b.area = 32'($urandom);
    end
    case ($urandom_range(0, 3))
      0: b.score = 16'd40000;
      1: b.score = 16'($urandom_range(0, 2000));
      default: b.score = 16'($urandom);
    endcase
    b.last = last;
    return b;
  endfunction

  task automatic queue_set(int n);
    for (int i = 0; i < n; i++) pending_boxes = {pending_boxes, rand_box(i == n - 1)};
  endtask

  task automatic push_box(int x0, int y0, int x1, int y1, longint area, int score, bit last);
    box_word_t b;
    b = '{16'(x0), 16'(y0), 16'(x1), 16'(y1), 32'(area), 16'(score), last};
    pending_boxes = {pending_boxes, b};
  endtask

  task automatic drain();
    wait (pending_boxes.size() == 0 && !box_valid_i && kept_due.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgScoreThr:   thr_score = val[15:0];
      CfgOverlapThr: thr_overlap = val;
      CfgDecay:      decay = val;
      default:       keep_max = val[7:0];
    endcase
  endtask

  task automatic set_regs(int s, int o, int d, int k);
    write_reg(CfgScoreThr, 17'(s));
    write_reg(CfgOverlapThr, 17'(o));
    write_reg(CfgDecay, 17'(d));
    write_reg(CfgKeepLimit, 17'(k & 8'hFF));
  endtask

  task automatic random_sets(int words);
    int n;
    while (words > 0) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 10);
      queue_set(n);
      words -= n;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed sets under the reset register values.
    push_box(0, 0, 0, 0, 0, 0, 1);                       // only box below threshold
    push_box(-32768, -32768, 32767, 32767, 64'hFFFFFFFF, 65535, 0);
    push_box(-32768, -32768, 32767, 32767, 64'hFFFFFFFF, 65535, 1); // identical boxes
    push_box(0, 0, 100, 100, 10000, 500, 0);
    push_box(100, 0, 200, 100, 10000, 500, 0);           // touching edge, no overlap
    push_box(5000, 5000, 6000, 6000, 1000000, 600, 0);   // disjoint, higher score
    push_box(0, 0, 100, 100, 0, 700, 0);
    push_box(0, 0, 100, 100, 0, 700, 1);                 // zero areas, union not positive
    push_box(0, 0, 1000, 1000, 1000000, 9000, 0);
    push_box(100, 100, 1100, 1100, 1000000, 9000, 0);    // equal scores keep load order
    push_box(50, 50, 1050, 1050, 1000000, 9001, 0);
    push_box(-1000, -1000, -10, -10, 980100, 3, 1);
    drain();

    set_regs(0, 65536, 65536, 64);
    send_idle_pct = 49;
    random_sets(50);
    drain();

    set_regs(65535, 0, 0, 0);
    send_idle_pct = 0;
    queue_set(3);
    drain();
    write_reg(CfgScoreThr, 17'd100);
    queue_set(4);
    drain();

    set_regs(1000, 32768, 50000, 5);
    recv_stall_pct = 49;
    random_sets(50);
    drain();

    set_regs(30000, 40000, 60000, -1);
    send_idle_pct = 28; recv_stall_pct = 28;
    long_hold_req = 1'b1;
    queue_set(64);
    queue_set(6);
    queue_set(5);
    random_sets(40);
    drain();

    set_regs(0, 29491, 65535, 3);
    send_idle_pct = 0; recv_stall_pct = 0;
    queue_set(66);                                       // overflow, data of the two words past 64 ignored
    random_sets(30);
    drain();

    $display("Ran %0d sets of %0d boxes in total, %0d kept words checked (%0d empty sets).",
             n_sets, n_boxes, n_results, n_none);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
sv/gbnms_pkg.sv
sv/gbnms_overlap.sv
sv/gbnms_seq.sv
sv/greedy_box_nms_unit.sv
dv/tb_top.sv
